// File: hw/rtl/hcbd_pkg.sv
// Shared types and constants for the chunked HTTP body decoder.
`default_nettype none

package hcbd_pkg;

  localparam int SIZE_BITS      = 24;
  localparam int MAX_LINE_BYTES = 31;
  localparam int LINE_CNT_BITS  = 6;
  localparam int LENGTH_BITS    = 24;

  localparam logic [LENGTH_BITS-1:0] TOTAL_MAX = {LENGTH_BITS{1'b1}};

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       end_of_body;
  } body_t;

  typedef struct packed {
    logic [1:0]             result_kind;
    logic [7:0]             payload_byte;
    logic [LENGTH_BITS-1:0] decoded_length;
  } result_t;

  typedef struct packed {
    logic  valid;
    body_t word;
  } slot_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_DATA_CR = 3'd2,
    PH_DATA_LF = 3'd3,
    PH_DRAIN   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    DS_BEFORE = 2'd0,
    DS_DIGITS = 2'd1,
    DS_DONE   = 2'd2,
    DS_FAIL   = 2'd3
  } dstage_t;

endpackage

`default_nettype wire

// File: hw/rtl/http_chunked_body_decoder.sv
// Top level of the chunked HTTP body decoder: input stage, decode, result register.
//
//   channel  dir  handshake                  word
//   body     in   body_valid / body_stall     body_t: body_byte, end_of_body
//   result   out  result_valid / result_stall result_t: kind, payload_byte, length
//
// One result word per body word, one word per cycle sustained while result_stall is low.
// A word passes through the input register, then the result register; the framing
// state updates as a word moves from the input register to the result register.
// rst (synchronous) returns the parser to the size line with all counts zero.
// result_stall holds the result register; body_stall rises only when the input
// register is full and cannot move on.
`default_nettype none

module http_chunked_body_decoder
  import hcbd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    body_valid,
  output logic         body_stall,
  input  wire body_t   body,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  slot_t   slot;
  logic    advance;
  result_t result_next;

  assign advance = !result_valid || !result_stall;

  hcbd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .body_valid (body_valid),
    .body_stall (body_stall),
    .body       (body),
    .advance    (advance),
    .slot       (slot)
  );

  hcbd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .slot        (slot),
    .advance     (advance),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= slot.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && slot.valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hcbd_in_stage.sv
// Input register stage holding one body word.
`default_nettype none

module hcbd_in_stage
  import hcbd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  body_valid,
  output logic       body_stall,
  input  wire body_t body,
  input  wire logic  advance,
  output slot_t      slot
);

  logic  valid_q;
  body_t word_q;

  assign body_stall = valid_q && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (!body_stall) begin
      valid_q <= body_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (body_valid && !body_stall) begin
      word_q <= body;
    end
  end

  assign slot.valid = valid_q;
  assign slot.word  = word_q;

endmodule

`default_nettype wire

// File: hw/rtl/hcbd_decode.sv
// Chunk framing state and per-word result logic.
`default_nettype none

module hcbd_decode
  import hcbd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire slot_t slot,
  input  wire logic  advance,
  output result_t    result_next
);

  phase_t                   phase, phase_next;
  logic [LINE_CNT_BITS-1:0] line_cnt, line_cnt_next;
  logic                     prev_cr, prev_cr_next;
  dstage_t                  dstage, dstage_next;
  logic [SIZE_BITS-1:0]     chunk, chunk_next;
  logic [LENGTH_BITS-1:0]   total, total_next;

  logic [7:0]               b;
  logic                     eob;
  logic                     hex_ok;
  logic [3:0]               hex_val;
  logic                     blank;
  logic [LINE_CNT_BITS-1:0] line_sum;
  logic [SIZE_BITS-1:0]     chunk_dec;
  kind_t                    kind;
  logic [7:0]               pbyte;
  logic [LENGTH_BITS-1:0]   len;

  assign b   = slot.word.body_byte;
  assign eob = slot.word.end_of_body;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_val = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // space, tab, LF, VT, FF, CR
  assign blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);

  assign line_sum  = line_cnt + LINE_CNT_BITS'(prev_cr) + LINE_CNT_BITS'(b != CH_CR);
  assign chunk_dec = (chunk != '0) ? chunk - SIZE_BITS'(1) : chunk;

  always_comb begin
    phase_next    = phase;
    line_cnt_next = line_cnt;
    prev_cr_next  = prev_cr;
    dstage_next   = dstage;
    chunk_next    = chunk;
    total_next    = total;
    kind          = KIND_NONE;
    pbyte         = 8'd0;
    len           = '0;

    unique case (phase)
      PH_SIZE: begin
        if (prev_cr && b == CH_LF) begin
          if (line_cnt == '0) begin
            kind = KIND_ERR;
          end else if (!(dstage == DS_DIGITS || dstage == DS_DONE)) begin
            kind = KIND_ERR;
          end else if (chunk == '0) begin
            kind = KIND_DONE;
          end else begin
            phase_next    = PH_DATA;
            line_cnt_next = '0;
            prev_cr_next  = 1'b0;
            dstage_next   = DS_BEFORE;
          end
        end else if (line_sum > LINE_CNT_BITS'(MAX_LINE_BYTES)) begin
          kind = KIND_ERR;
        end else begin
          line_cnt_next = line_sum;
          prev_cr_next  = (b == CH_CR);
          case (dstage)
            DS_BEFORE: begin
              if (hex_ok) begin
                chunk_next  = SIZE_BITS'(hex_val);
                dstage_next = DS_DIGITS;
              end else if (!blank) begin
                dstage_next = DS_FAIL;
              end
            end
            DS_DIGITS: begin
              if (hex_ok) begin
                if (chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
                  kind = KIND_ERR;
                end else begin
                  chunk_next = {chunk[SIZE_BITS-5:0], hex_val};
                end
              end else begin
                dstage_next = DS_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      PH_DATA: begin
        if (total == TOTAL_MAX) begin
          kind = KIND_ERR;
        end else begin
          kind       = KIND_BYTE;
          pbyte      = b;
          total_next = total + LENGTH_BITS'(1);
          chunk_next = chunk_dec;
          if (chunk_dec == '0) begin
            phase_next = PH_DATA_CR;
          end
        end
      end
      PH_DATA_CR: begin
        if (b == CH_CR) begin
          phase_next = PH_DATA_LF;
        end else begin
          kind = KIND_ERR;
        end
      end
      PH_DATA_LF: begin
        if (b == CH_LF) begin
          phase_next    = PH_SIZE;
          line_cnt_next = '0;
          prev_cr_next  = 1'b0;
          dstage_next   = DS_BEFORE;
          chunk_next    = '0;
        end else begin
          kind = KIND_ERR;
        end
      end
      default: begin
        phase_next = PH_DRAIN;
      end
    endcase

    // message end: finish, error or end of body (an error if it comes early)
    if (kind == KIND_DONE || kind == KIND_ERR || eob) begin
      if (kind == KIND_DONE) begin
        len = total;
      end else if (kind == KIND_ERR) begin
        pbyte = 8'd0;
      end else if (phase_next != PH_DRAIN) begin
        kind  = KIND_ERR;
        pbyte = 8'd0;
      end
      phase_next    = eob ? PH_SIZE : PH_DRAIN;
      line_cnt_next = '0;
      prev_cr_next  = 1'b0;
      dstage_next   = DS_BEFORE;
      chunk_next    = '0;
      total_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SIZE;
      line_cnt <= '0;
      prev_cr  <= 1'b0;
      dstage   <= DS_BEFORE;
      chunk    <= '0;
      total    <= '0;
    end else if (slot.valid && advance) begin
      phase    <= phase_next;
      line_cnt <= line_cnt_next;
      prev_cr  <= prev_cr_next;
      dstage   <= dstage_next;
      chunk    <= chunk_next;
      total    <= total_next;
    end
  end

  assign result_next.result_kind    = kind;
  assign result_next.payload_byte   = pbyte;
  assign result_next.decoded_length = len;

endmodule

`default_nettype wire
